>>> rtl/sine_tone_pcm_byte_generator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sine tone PCM byte generator
// Shared property forms, clocked on aclk and off during reset.
// ----------------------------------------------------------------------------
`ifndef SINE_TONE_PCM_BYTE_GENERATOR_DEFINES_SVH
`define SINE_TONE_PCM_BYTE_GENERATOR_DEFINES_SVH

// cons must hold in the same cycle as ante
`define STPG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define STPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/stpg_pkg.sv
// ----------------------------------------------------------------------------
// stpg_pkg
// Types, constants and codes shared by the sine tone PCM byte generator.
// ----------------------------------------------------------------------------
package stpg_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int MAX_CHANNELS_DEF    = 8;

    localparam int CC_W       = 4;         // channel_count register width
    localparam int CH_CALC_W  = CC_W + 1;  // room for channel count up to 16
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int QUEUE_DEPTH = 4;        // front to back item queue
    localparam int LA_DEPTH    = 16;       // precomputed samples in flight or held

    // sin(pi/2*x) odd polynomial, Q30
    localparam logic [31:0] POLY_A1 = 32'd1686629713;
    localparam logic [31:0] POLY_A3 = 32'd693598668;
    localparam logic [31:0] POLY_A5 = 32'd85569305;
    localparam logic [31:0] POLY_A7 = 32'd5026995;
    localparam logic [31:0] POLY_A9 = 32'd172272;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_INC     = 3'd0,
        REG_INITIAL_PHASE = 3'd1,
        REG_AMPLITUDE     = 3'd2,
        REG_DC_OFFSET     = 3'd3,
        REG_CHANNEL_COUNT = 3'd4,
        REG_SAMPLE_FORMAT = 3'd5,
        REG_MUTE          = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        FMT_U8  = 2'd0,
        FMT_S16 = 2'd1,
        FMT_S24 = 2'd2,
        FMT_S32 = 2'd3
    } fmt_t;

    typedef struct packed {
        logic            mute;
        logic [CC_W-1:0] channel_count;
        fmt_t            sample_format;
    } front_cfg_t;

    // one classified item as it travels from front to back
    typedef struct packed {
        logic       mute;
        logic       restart;
        logic       start;
        logic [1:0] byte_sel;
        logic       last;
        logic       bdone;
    } item_cls_t;

    typedef struct packed {
        logic signed [15:0] amplitude;
        logic signed [15:0] dc_offset;
        fmt_t               sample_format;
    } sine_cfg_t;

    typedef struct packed {
        logic        flush;
        logic        valid;
        logic [31:0] phase;
    } sine_req_t;

    typedef struct packed {
        logic [31:0] phase_increment;
        logic [31:0] initial_phase;
    } back_cfg_t;

endpackage

>>> rtl/stpg_front.sv
// ----------------------------------------------------------------------------
// stpg_front
// Accepts request items and tracks byte and channel position in the frame.
// ----------------------------------------------------------------------------
module stpg_front #(
    parameter int MAX_CHANNELS = stpg_pkg::MAX_CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  restart,
    input  logic                  buffer_end,
    input  stpg_pkg::front_cfg_t  cfg,
    output logic                  q_push,
    output stpg_pkg::item_cls_t   q_item,
    input  logic                  q_full
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW   = stpg_pkg::CH_CALC_W;
    localparam logic [CW-1:0] MAX_CH = CW'(MAX_CHANNELS);

    logic [1:0]      bis_reg, bis_next;
    logic [CH_W-1:0] ci_reg, ci_next;

    logic [2:0]    bps, bis0, bis1;
    logic [CW-1:0] chans, cc_ext, ci0, ci1;
    logic          last;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign cc_ext = {1'b0, cfg.channel_count};
    assign chans  = (cc_ext == '0) ? CW'(1) : ((cc_ext > MAX_CH) ? MAX_CH : cc_ext);
    assign bps    = {1'b0, cfg.sample_format} + 3'd1;

    always_comb begin
        bis0 = {1'b0, bis_reg};
        ci0  = CW'(ci_reg);
        if (restart) begin
            bis0 = '0;
            ci0  = '0;
        end
        // format shrank mid-frame
        if (bis0 >= bps) begin
            bis0 = '0;
            ci0  = ci0 + CW'(1);
        end
        // channel count shrank mid-frame
        if (ci0 >= chans) begin
            ci0  = '0;
            bis0 = '0;
        end
        bis1 = bis0 + 3'd1;
        ci1  = ci0;
        last = 1'b0;
        if (bis1 >= bps) begin
            bis1 = '0;
            ci1  = ci0 + CW'(1);
            if (ci1 >= chans) begin
                ci1  = '0;
                last = 1'b1;
            end
        end
    end

    always_comb begin
        q_item.bdone = buffer_end;
        if (cfg.mute) begin
            q_item.mute     = 1'b1;
            q_item.restart  = 1'b0;
            q_item.start    = 1'b0;
            q_item.byte_sel = 2'd0;
            q_item.last     = 1'b0;
        end else begin
            q_item.mute     = 1'b0;
            q_item.restart  = restart;
            q_item.start    = (bis0 == 3'd0) && (ci0 == '0);
            q_item.byte_sel = bis0[1:0];
            q_item.last     = last;
        end
    end

    assign bis_next = (q_push && !cfg.mute) ? bis1[1:0] : bis_reg;
    assign ci_next  = (q_push && !cfg.mute) ? CH_W'(ci1) : ci_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bis_reg <= '0;
            ci_reg  <= '0;
        end else begin
            bis_reg <= bis_next;
            ci_reg  <= ci_next;
        end
    end

endmodule

>>> rtl/stpg_queue.sv
// ----------------------------------------------------------------------------
// stpg_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module stpg_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  stpg_pkg::item_cls_t  push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output stpg_pkg::item_cls_t  head_item
);

    localparam int DEPTH = stpg_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    stpg_pkg::item_cls_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> rtl/stpg_sine.sv
// ----------------------------------------------------------------------------
// stpg_sine
// Eleven-stage sample pipeline: phase to sine, scale, offset, format.
// ----------------------------------------------------------------------------
module stpg_sine #(
    parameter int SINE_TABLE_BITS = stpg_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  stpg_pkg::sine_req_t  req,
    input  stpg_pkg::sine_cfg_t  cfg,
    output logic                 res_valid,
    output logic [31:0]          res_sample
);

    localparam int TB      = SINE_TABLE_BITS;
    localparam int QB      = TB - 2;
    localparam int NSTAGES = 11;

    logic [NSTAGES-1:0] vld_reg;

    logic [30:0] x_reg   [0:5];
    logic [30:0] xsq_reg [1:4];
    logic [31:0] t_reg   [2:6];
    logic        neg_reg [0:6];
    logic signed [15:0] sin_reg;
    logic signed [31:0] prod_reg;
    logic signed [15:0] v_reg;
    logic [31:0]        sample_reg;

    // stage 0: quarter-wave fold
    logic [TB-1:0] k;
    logic [QB-1:0] r;
    logic [QB:0]   rfold;
    logic [30:0]   x0;

    assign k     = req.phase[31 -: TB];
    assign r     = k[QB-1:0];
    assign rfold = k[QB] ? ({1'b1, {QB{1'b0}}} - {1'b0, r}) : {1'b0, r};
    assign x0    = {rfold, {(30 - QB){1'b0}}};

    // polynomial products, one per stage
    logic [61:0] mul_sq;
    logic [62:0] mul_a9, mul_a7, mul_a5, mul_a3, mul_x;

    assign mul_sq = x_reg[0] * x_reg[0];
    assign mul_a9 = xsq_reg[1] * stpg_pkg::POLY_A9;
    assign mul_a7 = xsq_reg[2] * t_reg[2];
    assign mul_a5 = xsq_reg[3] * t_reg[3];
    assign mul_a3 = xsq_reg[4] * t_reg[4];
    assign mul_x  = x_reg[5] * t_reg[5];

    // stage 7: round to Q15, clamp, sign
    logic [32:0] rnd;
    logic [15:0] mag;

    assign rnd = {1'b0, t_reg[6]} + 33'd16384;
    assign mag = (rnd[32:15] > 18'd32767) ? 16'd32767 : {1'b0, rnd[29:15]};

    // stage 8: amplitude scale
    logic signed [31:0] amp_prod;

    assign amp_prod = $signed(cfg.amplitude) * sin_reg;

    // stage 9: round back to Q15, add offset, saturate
    logic [32:0] psum;
    logic [18:0] vsum;
    logic [15:0] vsat;

    assign psum = {prod_reg[31], prod_reg} + 33'd16384;
    assign vsum = {{3{cfg.dc_offset[15]}}, cfg.dc_offset} + {psum[32], psum[32:15]};
    assign vsat = (vsum[18:15] == 4'b0000 || vsum[18:15] == 4'b1111) ? vsum[15:0] :
                  (vsum[18] ? 16'h8000 : 16'h7fff);

    // stage 10: sample format; negative values round toward zero
    logic [25:0] m255, u8sum;
    logic [31:0] a16, a16r;
    logic [47:0] b32, b32r;
    logic [31:0] fmt_out;

    assign m255  = {{2{v_reg[15]}}, v_reg, 8'd0} - {{10{v_reg[15]}}, v_reg};
    assign u8sum = m255 + 26'd8355840;
    assign a16   = {v_reg[15], v_reg, 15'd0} - {{16{v_reg[15]}}, v_reg};
    assign a16r  = v_reg[15] ? (a16 + 32'd32767) : a16;
    assign b32   = {v_reg[15], v_reg, 31'd0} - {{32{v_reg[15]}}, v_reg};
    assign b32r  = v_reg[15] ? (b32 + 48'd32767) : b32;

    always_comb begin
        unique case (cfg.sample_format)
            stpg_pkg::FMT_U8:  fmt_out = {24'd0, u8sum[23:16]};
            stpg_pkg::FMT_S16: fmt_out = {16'd0, a16r[30:15]};
            stpg_pkg::FMT_S24: fmt_out = {8'd0, b32r[46:23]};
            default:           fmt_out = b32r[46:15];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (req.flush) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[NSTAGES-2:0], req.valid};
        end
    end

    always_ff @(posedge aclk) begin
        x_reg[0]   <= x0;
        neg_reg[0] <= k[TB-1];

        x_reg[1]   <= x_reg[0];
        xsq_reg[1] <= mul_sq[60:30];
        neg_reg[1] <= neg_reg[0];

        x_reg[2]   <= x_reg[1];
        xsq_reg[2] <= xsq_reg[1];
        t_reg[2]   <= stpg_pkg::POLY_A7 - mul_a9[61:30];
        neg_reg[2] <= neg_reg[1];

        x_reg[3]   <= x_reg[2];
        xsq_reg[3] <= xsq_reg[2];
        t_reg[3]   <= stpg_pkg::POLY_A5 - mul_a7[61:30];
        neg_reg[3] <= neg_reg[2];

        x_reg[4]   <= x_reg[3];
        xsq_reg[4] <= xsq_reg[3];
        t_reg[4]   <= stpg_pkg::POLY_A3 - mul_a5[61:30];
        neg_reg[4] <= neg_reg[3];

        x_reg[5]   <= x_reg[4];
        t_reg[5]   <= stpg_pkg::POLY_A1 - mul_a3[61:30];
        neg_reg[5] <= neg_reg[4];

        t_reg[6]   <= mul_x[61:30];
        neg_reg[6] <= neg_reg[5];

        sin_reg    <= neg_reg[6] ? $signed(16'(-mag)) : $signed(mag);
        prod_reg   <= amp_prod;
        v_reg      <= $signed(vsat);
        sample_reg <= fmt_out;
    end

    assign res_valid  = vld_reg[NSTAGES-1];
    assign res_sample = sample_reg;

endmodule

>>> rtl/stpg_back.sv
// ----------------------------------------------------------------------------
// stpg_back
// Runs the phase ahead into the sample pipeline, holds the current sample
// and drives the output byte register.
// ----------------------------------------------------------------------------
module stpg_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  stpg_pkg::item_cls_t  q_item,
    output logic                 q_pop,
    input  stpg_pkg::back_cfg_t  cfg,
    input  logic                 cfg_write,
    output stpg_pkg::sine_req_t  sreq,
    input  logic                 res_valid,
    input  logic [31:0]          res_sample,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_data,
    output logic                 out_last,
    output logic                 out_bdone
);

    localparam int DEPTH = stpg_pkg::LA_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [31:0]      la_mem_reg [DEPTH];
    logic [PTR_W-1:0] la_wr_reg, la_rd_reg;
    logic [CNT_W-1:0] la_cnt_reg, credit_reg;
    logic [31:0]      arch_phase_reg, gen_phase_reg, held_reg;
    logic             rst_served_reg;
    logic             valid_reg, last_reg, bdone_reg;
    logic [7:0]       data_reg;

    logic        out_free, do_rflush, flush, can_go, consume, issue, la_push;
    logic [31:0] la_head, src;
    logic [7:0]  byte_sel_data;

    assign out_free  = !valid_reg || out_ready;
    assign do_rflush = q_valid && q_item.restart && !rst_served_reg;
    assign flush     = do_rflush || cfg_write;
    assign can_go    = q_valid && out_free && !do_rflush && !cfg_write &&
                       (q_item.mute || !q_item.start || (la_cnt_reg != '0));
    assign consume   = can_go && !q_item.mute && q_item.start;
    assign issue     = !flush && (credit_reg < CNT_W'(DEPTH));
    assign la_push   = res_valid && !flush;
    assign q_pop     = can_go;

    assign la_head       = la_mem_reg[la_rd_reg];
    assign src           = consume ? la_head : held_reg;
    assign byte_sel_data = src[{q_item.byte_sel, 3'b000} +: 8];

    assign sreq.flush = flush;
    assign sreq.valid = issue;
    assign sreq.phase = gen_phase_reg;

    always_ff @(posedge aclk) begin
        if (la_push) begin
            la_mem_reg[la_wr_reg] <= res_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_go) begin
            data_reg  <= q_item.mute ? 8'd0 : byte_sel_data;
            last_reg  <= q_item.last && !q_item.mute;
            bdone_reg <= q_item.bdone;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            la_wr_reg      <= '0;
            la_rd_reg      <= '0;
            la_cnt_reg     <= '0;
            credit_reg     <= '0;
            arch_phase_reg <= '0;
            gen_phase_reg  <= '0;
            held_reg       <= '0;
            rst_served_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end else begin
            if (can_go) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end

            if (can_go) begin
                rst_served_reg <= 1'b0;
            end else if (do_rflush) begin
                rst_served_reg <= 1'b1;
            end

            if (consume) begin
                held_reg <= la_head;
            end

            if (do_rflush) begin
                arch_phase_reg <= cfg.initial_phase;
            end else if (consume) begin
                arch_phase_reg <= arch_phase_reg + cfg.phase_increment;
            end

            if (flush) begin
                gen_phase_reg <= do_rflush ? cfg.initial_phase : arch_phase_reg;
                credit_reg    <= '0;
                la_wr_reg     <= '0;
                la_rd_reg     <= '0;
                la_cnt_reg    <= '0;
            end else begin
                if (issue) begin
                    gen_phase_reg <= gen_phase_reg + cfg.phase_increment;
                end
                unique case ({issue, consume})
                    2'b10:   credit_reg <= credit_reg + CNT_W'(1);
                    2'b01:   credit_reg <= credit_reg - CNT_W'(1);
                    default: credit_reg <= credit_reg;
                endcase
                if (la_push) begin
                    la_wr_reg <= (la_wr_reg == PTR_W'(DEPTH - 1)) ? '0 : la_wr_reg + PTR_W'(1);
                end
                if (consume) begin
                    la_rd_reg <= (la_rd_reg == PTR_W'(DEPTH - 1)) ? '0 : la_rd_reg + PTR_W'(1);
                end
                unique case ({la_push, consume})
                    2'b10:   la_cnt_reg <= la_cnt_reg + CNT_W'(1);
                    2'b01:   la_cnt_reg <= la_cnt_reg - CNT_W'(1);
                    default: la_cnt_reg <= la_cnt_reg;
                endcase
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;
    assign out_bdone = bdone_reg;

endmodule

>>> rtl/sine_tone_pcm_byte_generator.sv
// ----------------------------------------------------------------------------
// sine_tone_pcm_byte_generator
// A frame start waits for the lookahead to refill after a flush. Throughput: 1 byte
// per cycle without stalls; the 11-stage sine pipeline runs up to 16 phases ahead.
// Reset: sync active-low aresetn; register defaults, phase zero, frame start.
// ----------------------------------------------------------------------------
`include "sine_tone_pcm_byte_generator_defines.svh"

module sine_tone_pcm_byte_generator #(
    parameter int SINE_TABLE_BITS = stpg_pkg::SINE_TABLE_BITS_DEF,
    parameter int MAX_CHANNELS    = stpg_pkg::MAX_CHANNELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [0] restart
    input  logic                            s_tlast,   // buffer_end
    // PCM byte items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] data_byte
    output logic                            m_tlast,   // frame_last
    output logic [0:0]                      m_tuser,   // [0] buffer_done
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [stpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stpg_pkg::CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Register file. Writes are always taken; unknown indexes are dropped.
    // ------------------------------------------------------------------
    logic [31:0]                 phase_inc_reg;
    logic [31:0]                 init_phase_reg;
    logic signed [15:0]          amplitude_reg;
    logic signed [15:0]          dc_offset_reg;
    logic [stpg_pkg::CC_W-1:0]   chan_count_reg;
    stpg_pkg::fmt_t              format_reg;
    logic                        mute_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_inc_reg  <= '0;
            init_phase_reg <= '0;
            amplitude_reg  <= '0;
            dc_offset_reg  <= '0;
            chan_count_reg <= stpg_pkg::CC_W'(2);
            format_reg     <= stpg_pkg::FMT_S16;
            mute_reg       <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                stpg_pkg::REG_PHASE_INC:     phase_inc_reg  <= cfg_data[31:0];
                stpg_pkg::REG_INITIAL_PHASE: init_phase_reg <= cfg_data[31:0];
                stpg_pkg::REG_AMPLITUDE:     amplitude_reg  <= $signed(cfg_data[15:0]);
                stpg_pkg::REG_DC_OFFSET:     dc_offset_reg  <= $signed(cfg_data[15:0]);
                stpg_pkg::REG_CHANNEL_COUNT: chan_count_reg <= cfg_data[stpg_pkg::CC_W-1:0];
                stpg_pkg::REG_SAMPLE_FORMAT: format_reg     <= stpg_pkg::fmt_t'(cfg_data[1:0]);
                stpg_pkg::REG_MUTE:          mute_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    stpg_pkg::front_cfg_t front_cfg;
    stpg_pkg::sine_cfg_t  sine_cfg;
    stpg_pkg::back_cfg_t  back_cfg;

    assign front_cfg.mute          = mute_reg;
    assign front_cfg.channel_count = chan_count_reg;
    assign front_cfg.sample_format = format_reg;

    assign sine_cfg.amplitude      = amplitude_reg;
    assign sine_cfg.dc_offset      = dc_offset_reg;
    assign sine_cfg.sample_format  = format_reg;

    assign back_cfg.phase_increment = phase_inc_reg;
    assign back_cfg.initial_phase   = init_phase_reg;

    // ------------------------------------------------------------------
    // Front: frame position tracking, one item per cycle into the queue while it is not full.
    // ------------------------------------------------------------------
    logic                 push, q_full, q_valid, q_pop;
    stpg_pkg::item_cls_t  push_item, q_item;

    stpg_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .restart    (s_tdata[0]),
        .buffer_end (s_tlast),
        .cfg        (front_cfg),
        .q_push     (push),
        .q_item     (push_item),
        .q_full     (q_full)
    );

    stpg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_item)
    );

    // ------------------------------------------------------------------
    // Back: sample lookahead and output register. A restart or a register
    // write flushes the lookahead and refills it from the initial or the live phase.
    // ------------------------------------------------------------------
    stpg_pkg::sine_req_t  sreq;
    logic                 res_valid;
    logic [31:0]          res_sample;
    logic                 out_bdone;

    stpg_sine #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (sreq),
        .cfg        (sine_cfg),
        .res_valid  (res_valid),
        .res_sample (res_sample)
    );

    stpg_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .cfg        (back_cfg),
        .cfg_write  (cfg_valid),
        .sreq       (sreq),
        .res_valid  (res_valid),
        .res_sample (res_sample),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_last   (m_tlast),
        .out_bdone  (out_bdone)
    );

    assign m_tuser[0] = out_bdone;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `STPG_ASSERT_SAME(a_pop_needs_item, q_pop, q_valid, "item queue popped while empty")
    `STPG_ASSERT_SAME(a_restart_starts_frame, q_pop && q_item.restart, q_item.start,
                      "restart item not at frame start")
    `STPG_ASSERT_NEXT(a_flush_drops_results, sreq.flush, !res_valid, "sample survived a flush")
    `STPG_ASSERT_NEXT(a_mute_gives_zero, q_pop && q_item.mute,
                      m_tvalid && (m_tdata == 8'd0) && !m_tlast,
                      "muted item gave nonzero byte")

endmodule

>>> verif/sine_tone_pcm_byte_generator_tb.sv
// ----------------------------------------------------------------------------
// sine_tone_pcm_byte_generator_tb
// Streams byte requests into the tone generator and checks every PCM byte,
// its frame-last flag and its buffer-done flag against an in-bench
// oscillator model, across many register settings, with random idle bursts.
// ----------------------------------------------------------------------------
module sine_tone_pcm_byte_generator_tb;

    localparam int SINE_BITS  = stpg_pkg::SINE_TABLE_BITS_DEF;
    localparam int QTR_BITS   = SINE_BITS - 2;
    localparam int MAX_CH     = stpg_pkg::MAX_CHANNELS_DEF;
    localparam int REQ_TARGET = 1350;
    localparam int TAIL_REQS  = 100;
    localparam int SETTLE_CYC = 20;   // covers the sine pipeline refill

    // sin(pi/2*x) odd polynomial terms, Q30
    localparam longint unsigned SIN_A1 = 64'd1686629713;
    localparam longint unsigned SIN_A3 = 64'd693598668;
    localparam longint unsigned SIN_A5 = 64'd85569305;
    localparam longint unsigned SIN_A7 = 64'd5026995;
    localparam longint unsigned SIN_A9 = 64'd172272;

    typedef struct packed {
        logic restart;
        logic buffer_end;
        logic drain;        // hold this request until every byte is back
    } byte_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } pcm_byte_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [stpg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [stpg_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // oscillator model: register copy
    logic [31:0]    tone_inc;
    logic [31:0]    tone_init;
    shortint        tone_amp;
    shortint        tone_dc;
    logic [3:0]     tone_chans;
    stpg_pkg::fmt_t tone_fmt;
    logic           tone_mute;
    // oscillator model: running state
    logic [31:0] tone_phase;
    logic [31:0] tone_held;
    int unsigned tone_byte_pos;
    int unsigned tone_chan_pos;

    byte_req_t req_queue[$];     // requests not yet presented
    pcm_byte_t pcm_queue[$];     // bytes owed by the block, oldest first
    byte_req_t cur_req;
    logic      req_in_flight = 1'b0;
    logic      next_valid;
    int        gap_left      = 0;
    int        stall_left    = 0;
    int        reqs_queued   = 0;
    int        mismatches    = 0;
    bit        idle_on       = 1'b1;
    bit        calm          = 1'b0;

    sine_tone_pcm_byte_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [0] restart
        .s_tlast   (s_tlast),    // buffer_end
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] data_byte
        .m_tlast   (m_tlast),    // frame_last
        .m_tuser   (m_tuser),    // [0] buffer_done
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #12_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Oscillator model
    // ------------------------------------------------------------------

    // Q15 sine of the top table bits of the phase, quarter-wave folded
    function automatic int tone_sine(logic [31:0] ph);
        logic [31:0]     k, quad, r;
        longint unsigned x, x2, t, m;
        k    = ph >> (32 - SINE_BITS);
        quad = (k >> QTR_BITS) & 32'd3;
        r    = k & ((32'd1 << QTR_BITS) - 32'd1);
        if (quad[0]) begin
            x = 64'((32'd1 << QTR_BITS) - r) << (30 - QTR_BITS);
        end else begin
            x = 64'(r) << (30 - QTR_BITS);
        end
        x2 = (x * x) >> 30;
        t  = SIN_A7 - ((x2 * SIN_A9) >> 30);
        t  = SIN_A5 - ((x2 * t) >> 30);
        t  = SIN_A3 - ((x2 * t) >> 30);
        t  = SIN_A1 - ((x2 * t) >> 30);
        t  = (x * t) >> 30;
        m  = (t + 64'd16384) >> 15;
        if (m > 64'd32767) m = 64'd32767;
        return (quad >= 32'd2) ? -int'(m) : int'(m);
    endfunction

    // one sample in the current format, packed little-endian in 32 bits
    function automatic logic [31:0] tone_sample(logic [31:0] ph);
        longint p, v, w;
        p = longint'(tone_amp) * longint'(tone_sine(ph));
        v = longint'(tone_dc) + ((p + 16384) >>> 15);
        if (v > 32767)  v = 32767;
        if (v < -32768) v = -32768;
        case (tone_fmt)
            stpg_pkg::FMT_U8:  return 32'((v * 255 + 255 * 32768) / 65536);
            stpg_pkg::FMT_S16: return 32'((v * 32767) / 32768) & 32'h0000_FFFF;
            stpg_pkg::FMT_S24: begin
                // 32-bit scale, then floor shift down to 24 bits
                w = (v * 64'sd2147483647) / 32768;
                return 32'(((w + 64'sd2147483648) >>> 8) - 8388608) & 32'h00FF_FFFF;
            end
            default: return 32'((v * 64'sd2147483647) / 32768);
        endcase
    endfunction

    // works out the byte that one accepted request must produce
    function automatic void next_pcm_byte(logic restart, logic buffer_end);
        int unsigned chans, bps;
        pcm_byte_t   b;
        b.data = 8'd0;
        b.last = 1'b0;
        b.done = buffer_end;
        if (tone_mute) begin
            // zero bytes, restart ignored, nothing advances
            pcm_queue.push_back(b);
            return;
        end
        chans = tone_chans;
        if (chans < 1)      chans = 1;
        if (chans > MAX_CH) chans = MAX_CH;
        bps = int'(tone_fmt) + 1;
        if (restart) begin
            tone_phase    = tone_init;
            tone_byte_pos = 0;
            tone_chan_pos = 0;
        end
        // positions left over from a larger format or channel count wrap
        if (tone_byte_pos >= bps) begin
            tone_byte_pos = 0;
            tone_chan_pos++;
        end
        if (tone_chan_pos >= chans) begin
            tone_chan_pos = 0;
            tone_byte_pos = 0;
        end
        if (tone_byte_pos == 0 && tone_chan_pos == 0) begin
            tone_held  = tone_sample(tone_phase);
            tone_phase = tone_phase + tone_inc;
        end
        b.data = 8'(tone_held >> (8 * (tone_byte_pos & 3)));
        tone_byte_pos++;
        if (tone_byte_pos >= bps) begin
            tone_byte_pos = 0;
            tone_chan_pos++;
            if (tone_chan_pos >= chans) begin
                tone_chan_pos = 0;
                b.last = 1'b1;
            end
        end
        pcm_queue.push_back(b);
    endfunction

    function automatic void tone_reset();
        tone_inc      = '0;
        tone_init     = '0;
        tone_amp      = 0;
        tone_dc       = 0;
        tone_chans    = 4'd2;
        tone_fmt      = stpg_pkg::FMT_S16;
        tone_mute     = 1'b0;
        tone_phase    = '0;
        tone_held     = '0;
        tone_byte_pos = 0;
        tone_chan_pos = 0;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: one item per handshake, random gaps between items
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            gap_left = 0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                next_pcm_byte(cur_req.restart, cur_req.buffer_end);
                req_in_flight = 1'b0;
                next_valid    = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (req_queue.size() != 0 &&
                             !(req_queue[0].drain && pcm_queue.size() != 0)) begin
                    if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
                        // random-length idle burst, this cycle included
                        gap_left = $urandom_range(0, 16);
                    end else begin
                        cur_req       = req_queue.pop_front();
                        req_in_flight = 1'b1;
                        next_valid    = 1'b1;
                        s_tdata <= {7'd0, cur_req.restart};
                        s_tlast <= cur_req.buffer_end;
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Byte monitor: compares each accepted item, random ready stalls
    // ------------------------------------------------------------------
    function automatic void flag_error(string what, int unsigned want, int unsigned got);
        mismatches++;
        $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pcm_queue.size() == 0) begin
                    mismatches++;
                    $display("%0t: byte %0h expected none got one", $time, m_tdata);
                end else begin
                    if (m_tdata !== pcm_queue[0].data)
                        flag_error("data_byte", pcm_queue[0].data, m_tdata);
                    if (m_tlast !== pcm_queue[0].last)
                        flag_error("frame_last", pcm_queue[0].last, m_tlast);
                    if (m_tuser[0] !== pcm_queue[0].done)
                        flag_error("buffer_done", pcm_queue[0].done, m_tuser[0]);
                    void'(pcm_queue.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && !calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 16);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    task automatic push_req(bit restart, bit buffer_end, bit drain);
        req_queue.push_back('{restart: restart, buffer_end: buffer_end, drain: drain});
        reqs_queued++;
    endtask

    // block idle: nothing queued, nothing on the bus, every byte back
    task automatic settle();
        while (req_queue.size() != 0 || req_in_flight || pcm_queue.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic cfg_write(stpg_pkg::reg_idx_t idx, logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            stpg_pkg::REG_PHASE_INC:     tone_inc   = value;
            stpg_pkg::REG_INITIAL_PHASE: tone_init  = value;
            stpg_pkg::REG_AMPLITUDE:     tone_amp   = shortint'(value[15:0]);
            stpg_pkg::REG_DC_OFFSET:     tone_dc    = shortint'(value[15:0]);
            stpg_pkg::REG_CHANNEL_COUNT: tone_chans = value[3:0];
            stpg_pkg::REG_SAMPLE_FORMAT: tone_fmt   = stpg_pkg::fmt_t'(value[1:0]);
            stpg_pkg::REG_MUTE:          tone_mute  = value[0];
            default: ;
        endcase
    endtask

    task automatic load_setup(logic [31:0] inc, logic [31:0] init, logic [15:0] amp,
                              logic [15:0] dc, logic [3:0] chans, stpg_pkg::fmt_t fmt,
                              logic mute);
        cfg_write(stpg_pkg::REG_PHASE_INC, inc);
        cfg_write(stpg_pkg::REG_INITIAL_PHASE, init);
        cfg_write(stpg_pkg::REG_AMPLITUDE, {16'd0, amp});
        cfg_write(stpg_pkg::REG_DC_OFFSET, {16'hFFFF, dc});
        cfg_write(stpg_pkg::REG_CHANNEL_COUNT, {28'd0, chans});
        cfg_write(stpg_pkg::REG_SAMPLE_FORMAT, {30'd0, fmt});
        cfg_write(stpg_pkg::REG_MUTE, {31'd0, mute});
    endtask

    // random register value, leaning on the extremes; upper bits of the
    // narrow registers carry junk that must be ignored
    function automatic logic [31:0] pick_setting(stpg_pkg::reg_idx_t idx);
        logic [31:0] junk;
        junk = $urandom;
        case (idx)
            stpg_pkg::REG_PHASE_INC, stpg_pkg::REG_INITIAL_PHASE: begin
                case ($urandom_range(0, 6))
                    0:       return 32'd0;
                    1:       return 32'hFFFF_FFFF;
                    2:       return 32'h8000_0000;
                    3:       return 32'd1;
                    4:       return $urandom_range(0, 32'h0100_0000);
                    default: return $urandom;
                endcase
            end
            stpg_pkg::REG_AMPLITUDE, stpg_pkg::REG_DC_OFFSET: begin
                case ($urandom_range(0, 5))
                    0:       return {junk[31:16], 16'h8000};
                    1:       return {junk[31:16], 16'h7FFF};
                    2:       return {junk[31:16], 16'h0000};
                    default: return junk;
                endcase
            end
            stpg_pkg::REG_CHANNEL_COUNT: begin
                // mostly legal counts, sometimes zero or above the maximum
                if ($urandom_range(0, 3) == 0)
                    return {junk[31:4], 4'($urandom_range(0, 15))};
                return {junk[31:4], 4'($urandom_range(1, MAX_CH))};
            end
            stpg_pkg::REG_SAMPLE_FORMAT: return {junk[31:2], 2'($urandom_range(0, 3))};
            default:           return {junk[31:1], 1'($urandom_range(0, 5) == 0)};
        endcase
    endfunction

    initial begin
        int n;
        int ri;
        tone_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: silent tone, 16-bit stereo
        push_req(0, 0, 0);
        push_req(0, 1, 0);
        push_req(1, 0, 0);
        push_req(0, 0, 0);
        push_req(0, 0, 0);
        push_req(0, 1, 0);
        settle();

        // full scale 32-bit mono, quarter-turn steps from the last phase code
        load_setup(32'h4000_0000, 32'hFFFF_FFFF, 16'h7FFF, 16'h0000, 4'd1,
                   stpg_pkg::FMT_S32, 1'b0);
        push_req(1, 0, 0);
        repeat (6) push_req(0, 0, 0);
        push_req(0, 1, 0);
        settle();

        // negative extremes saturate low; count above the maximum, 8-bit
        load_setup(32'h0000_0001, 32'h4000_0000, 16'h8000, 16'h8000, 4'd15,
                   stpg_pkg::FMT_U8, 1'b0);
        push_req(1, 0, 0);
        repeat (3) push_req(0, 0, 0);
        push_req(0, 1, 0);
        settle();

        // mute: zeros, restart ignored, state frozen mid-frame
        cfg_write(stpg_pkg::REG_MUTE, 32'd1);
        push_req(1, 1, 0);
        push_req(0, 0, 0);
        push_req(1, 0, 0);
        settle();

        // 24-bit, channel count zero, positive saturation, restart mid-frame;
        // the third item waits for every byte before going out
        cfg_write(stpg_pkg::REG_MUTE, 32'd0);
        cfg_write(stpg_pkg::REG_SAMPLE_FORMAT, {30'd0, stpg_pkg::FMT_S24});
        cfg_write(stpg_pkg::REG_CHANNEL_COUNT, 32'd0);
        cfg_write(stpg_pkg::REG_DC_OFFSET, 32'h0000_7FFF);
        push_req(0, 0, 0);
        push_req(1, 0, 0);
        push_req(0, 0, 1);
        push_req(0, 1, 0);
        settle();

        // random phases, each with a fresh mix of register writes
        while (reqs_queued < REQ_TARGET - TAIL_REQS) begin
            for (ri = 0; ri < 7; ri++) begin
                if ($urandom_range(0, 1) == 1)
                    cfg_write(stpg_pkg::reg_idx_t'(ri), pick_setting(stpg_pkg::reg_idx_t'(ri)));
            end
            idle_on = ($urandom_range(0, 2) != 0);
            n = $urandom_range(40, 160);
            repeat (n)
                push_req($urandom_range(0, 19) == 0, $urandom_range(0, 5) == 0,
                         $urandom_range(0, 79) == 0);
            settle();
        end

        // last stretch at full rate, no stalls
        cfg_write(stpg_pkg::REG_MUTE, 32'd0);
        calm = 1'b1;
        repeat (TAIL_REQS)
            push_req($urandom_range(0, 19) == 0, $urandom_range(0, 5) == 0, 1'b0);
        settle();

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
